/* rtl/rv32im_integer_alu_assert.svh */
// assertion macros for the integer alu
`ifndef RV32IM_INTEGER_ALU_ASSERT_SVH
`define RV32IM_INTEGER_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define ALU_ASSERT_IMPLY(label, clk_s, rst_s, lhs, rhs) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define ALU_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ALU_ASSERT_IMPLY(label, clk_s, rst_s, lhs, rhs)
`define ALU_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs)
`endif
`endif

/* rtl/rvalu_pkg.sv */
package rvalu_pkg;

    localparam int unsigned CELLS = 32;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_SUB    = 5'd1,
        CMD_SLL    = 5'd2,
        CMD_SLT    = 5'd3,
        CMD_SLTU   = 5'd4,
        CMD_XOR    = 5'd5,
        CMD_SRL    = 5'd6,
        CMD_SRA    = 5'd7,
        CMD_OR     = 5'd8,
        CMD_AND    = 5'd9,
        CMD_MUL    = 5'd10,
        CMD_MULH   = 5'd11,
        CMD_MULHSU = 5'd12,
        CMD_MULHU  = 5'd13,
        CMD_DIV    = 5'd14,
        CMD_DIVU   = 5'd15,
        CMD_REM    = 5'd16,
        CMD_REMU   = 5'd17,
        CMD_LUI    = 5'd18,
        CMD_AUIPC  = 5'd19
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_DONE,
        KIND_MUL_LO,
        KIND_MUL_HI,
        KIND_QUO,
        KIND_REM
    } kind_t;

    // word moving along the chain
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [4:0]  dest;
        logic [31:0] value;
        logic        neg_q;
        logic        neg_r;
        logic        div_zero;
        logic [31:0] orig_a;
        logic [32:0] mcand;
        logic [63:0] acc;
        logic [31:0] quo;
        logic [31:0] dvs;
    } cell_word_t;

endpackage

/* rtl/rvalu_cell.sv */
module rvalu_cell
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [4:0]              step,
    input  rvalu_pkg::cell_word_t   prev,
    output rvalu_pkg::cell_word_t   cur
);

    rvalu_pkg::cell_word_t cur_reg;
    rvalu_pkg::cell_word_t cur_next;
    logic        valid_reg;
    logic [63:0] mul_addend;
    logic [32:0] rem_shift;
    logic [33:0] rem_diff;

    always_comb
    begin
        cur_next = prev;
        mul_addend = '0;
        rem_shift = '0;
        rem_diff = '0;
        unique case (prev.kind)
            rvalu_pkg::KIND_MUL_LO, rvalu_pkg::KIND_MUL_HI:
            begin
                // sign-extended multiplicand at this cell's bit weight, top bit negative
                mul_addend = {{31{prev.mcand[32]}}, prev.mcand} << step;
                if (prev.quo[0])
                begin
                    if (step == 5'd31 && prev.neg_q)
                        cur_next.acc = prev.acc - mul_addend;
                    else
                        cur_next.acc = prev.acc + mul_addend;
                end
                cur_next.quo = {1'b0, prev.quo[31:1]};
            end
            rvalu_pkg::KIND_QUO, rvalu_pkg::KIND_REM:
            begin
                rem_shift = {prev.acc[31:0], prev.quo[31]};
                rem_diff  = {1'b0, rem_shift} - {2'b00, prev.dvs};
                cur_next.quo = {prev.quo[30:0], ~rem_diff[33]};
                cur_next.acc = {32'd0, rem_diff[33] ? rem_shift[31:0] : rem_diff[31:0]};
            end
            default:
            begin
                cur_next.acc = prev.acc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            cur_reg <= cur_next;
    end

    always_comb
    begin
        cur = cur_reg;
        cur.valid = valid_reg;
    end

endmodule

/* rtl/rv32im_integer_alu.sv */
// every operation passes through all 32 cell registers and then the output register
// throughput: one word per cycle unless stalled; the shift-add / restoring-divide chain
// sets latency, and the whole chain stalls while the output register is full and not taken
// reset clears all valid flags; payload registers are not reset
`include "rv32im_integer_alu_assert.svh"
module rv32im_integer_alu
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[4:0], operand_a[36:5], operand_b[68:37], program_counter[100:69],
    // dest_index[105:101], zero pad
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[31:0], result_dest[36:32], zero pad
    output logic [39:0]  m_axis_tdata
);

    rvalu_pkg::cell_word_t chain [0:rvalu_pkg::CELLS];
    rvalu_pkg::cell_word_t head;
    logic [4:0]  cmd;
    logic [31:0] a, b, pc;
    logic [4:0]  sh;
    logic        advance;
    logic        sa, sb, an, bn;
    logic [31:0] ma, mb;
    logic        out_valid_reg;
    logic [31:0] out_value_reg, fin_value;
    logic [4:0]  out_dest_reg;
    rvalu_pkg::cell_word_t tail;

    assign cmd = s_axis_tdata[4:0];
    assign a   = s_axis_tdata[36:5];
    assign b   = s_axis_tdata[68:37];
    assign pc  = s_axis_tdata[100:69];
    assign sh  = b[4:0];

    assign advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    assign sa = (cmd == rvalu_pkg::CMD_MULH) || (cmd == rvalu_pkg::CMD_MULHSU);
    assign sb = (cmd == rvalu_pkg::CMD_MULH);
    assign an = a[31] && ((cmd == rvalu_pkg::CMD_DIV) || (cmd == rvalu_pkg::CMD_REM));
    assign bn = b[31] && ((cmd == rvalu_pkg::CMD_DIV) || (cmd == rvalu_pkg::CMD_REM));
    assign ma = an ? (32'd0 - a) : a;
    assign mb = bn ? (32'd0 - b) : b;

    always_comb
    begin
        head = '0;
        head.valid = s_axis_tvalid;
        head.dest  = s_axis_tdata[105:101];
        head.kind  = rvalu_pkg::KIND_DONE;
        head.orig_a = a;
        unique case (cmd)
            rvalu_pkg::CMD_ADD:   head.value = a + b;
            rvalu_pkg::CMD_SUB:   head.value = a - b;
            rvalu_pkg::CMD_SLL:   head.value = a << sh;
            rvalu_pkg::CMD_SLT:   head.value = {31'd0, $signed(a) < $signed(b)};
            rvalu_pkg::CMD_SLTU:  head.value = {31'd0, a < b};
            rvalu_pkg::CMD_XOR:   head.value = a ^ b;
            rvalu_pkg::CMD_SRL:   head.value = a >> sh;
            rvalu_pkg::CMD_SRA:   head.value = 32'($signed(a) >>> sh);
            rvalu_pkg::CMD_OR:    head.value = a | b;
            rvalu_pkg::CMD_AND:   head.value = a & b;
            rvalu_pkg::CMD_LUI:   head.value = b;
            rvalu_pkg::CMD_AUIPC: head.value = pc + b;
            rvalu_pkg::CMD_MUL, rvalu_pkg::CMD_MULH,
            rvalu_pkg::CMD_MULHSU, rvalu_pkg::CMD_MULHU:
            begin
                head.kind  = (cmd == rvalu_pkg::CMD_MUL) ? rvalu_pkg::KIND_MUL_LO
                                                         : rvalu_pkg::KIND_MUL_HI;
                head.mcand = {sa & a[31], a};
                head.quo   = b;
                head.neg_q = sb & b[31];
            end
            rvalu_pkg::CMD_DIV, rvalu_pkg::CMD_DIVU:
            begin
                head.kind = rvalu_pkg::KIND_QUO;
                head.quo  = ma;
                head.dvs  = mb;
                head.neg_q = an ^ bn;
                head.div_zero = (b == 32'd0);
            end
            rvalu_pkg::CMD_REM, rvalu_pkg::CMD_REMU:
            begin
                head.kind = rvalu_pkg::KIND_REM;
                head.quo  = ma;
                head.dvs  = mb;
                head.neg_r = an;
                head.div_zero = (b == 32'd0);
            end
            default: head.value = 32'd0;
        endcase
    end

    assign chain[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < rvalu_pkg::CELLS; gi++)
        begin : g_cell
            rvalu_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .step    (5'(gi)),
                .prev    (chain[gi]),
                .cur     (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[rvalu_pkg::CELLS];

    always_comb
    begin
        unique case (tail.kind)
            rvalu_pkg::KIND_MUL_LO: fin_value = tail.acc[31:0];
            rvalu_pkg::KIND_MUL_HI: fin_value = tail.acc[63:32];
            rvalu_pkg::KIND_QUO:
                fin_value = tail.div_zero ? 32'hFFFF_FFFF
                          : (tail.neg_q ? 32'd0 - tail.quo : tail.quo);
            rvalu_pkg::KIND_REM:
                fin_value = tail.div_zero ? tail.orig_a
                          : (tail.neg_r ? 32'd0 - tail.acc[31:0] : tail.acc[31:0]);
            default: fin_value = tail.value;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= fin_value;
            out_dest_reg  <= tail.dest;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_dest_reg, out_value_reg};

    `ALU_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid_reg, s_axis_tready)
    `ALU_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ALU_ASSERT_NEXT(a_tail_to_out, clk, rst_n, advance && tail.valid, m_axis_tvalid)

endmodule

/* tb/rv32im_integer_alu_test.sv */
`timescale 1ns / 100ps
module rv32im_integer_alu_test;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  dest;
    } alu_result_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // command, operand_a, operand_b, program_counter, dest_index, zero pad
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // result_value, result_dest, zero pad
    logic [39:0]  m_axis_tdata;

    alu_result_t  pending_results[$];
    int           mismatch_count = 0;
    int           word_count = 0;
    int           result_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           timed_out = 1'b0;

    rv32im_integer_alu dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] signed_high_product(logic [31:0] a, logic [31:0] b,
                                                        bit a_signed, bit b_signed);
        logic [65:0] ea;
        logic [65:0] eb;
        logic [65:0] p;
        ea = a_signed ? {{34{a[31]}}, a} : {34'd0, a};
        eb = b_signed ? {{34{b[31]}}, b} : {34'd0, b};
        p = ea * eb;
        return p[63:32];
    endfunction

    function automatic logic [31:0] alu_compute(logic [4:0] cmd, logic [31:0] a,
                                                logic [31:0] b, logic [31:0] pc);
        logic [4:0]  sh;
        logic [63:0] prod;
        sh = b[4:0];
        prod = 64'(a) * 64'(b);
        case (cmd)
            rvalu_pkg::CMD_ADD:    return a + b;
            rvalu_pkg::CMD_SUB:    return a - b;
            rvalu_pkg::CMD_SLL:    return a << sh;
            rvalu_pkg::CMD_SLT:    return {31'd0, $signed(a) < $signed(b)};
            rvalu_pkg::CMD_SLTU:   return {31'd0, a < b};
            rvalu_pkg::CMD_XOR:    return a ^ b;
            rvalu_pkg::CMD_SRL:    return a >> sh;
            rvalu_pkg::CMD_SRA:    return $unsigned($signed(a) >>> sh);
            rvalu_pkg::CMD_OR:     return a | b;
            rvalu_pkg::CMD_AND:    return a & b;
            rvalu_pkg::CMD_MUL:    return prod[31:0];
            rvalu_pkg::CMD_MULH:   return signed_high_product(a, b, 1, 1);
            rvalu_pkg::CMD_MULHSU: return signed_high_product(a, b, 1, 0);
            rvalu_pkg::CMD_MULHU:  return prod[63:32];
            rvalu_pkg::CMD_DIV:
                if (b == '0) return '1;
                else if (a == 32'h8000_0000 && b == '1) return a;
                else return $unsigned($signed(a) / $signed(b));
            rvalu_pkg::CMD_DIVU:   return (b == '0) ? '1 : a / b;
            rvalu_pkg::CMD_REM:
                if (b == '0) return a;
                else if (a == 32'h8000_0000 && b == '1) return '0;
                else return $unsigned($signed(a) % $signed(b));
            rvalu_pkg::CMD_REMU:   return (b == '0) ? a : a % b;
            rvalu_pkg::CMD_LUI:    return b;
            rvalu_pkg::CMD_AUIPC:  return pc + b;
            default:               return '0;
        endcase
    endfunction

    task automatic send_word(logic [4:0] cmd, logic [31:0] a, logic [31:0] b,
                             logic [31:0] pc, logic [4:0] rd);
        alu_result_t exp_res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, rd, pc, b, a, cmd};
        exp_res.value = alu_compute(cmd, a, b, pc);
        exp_res.dest  = rd;
        pending_results.push_back(exp_res);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        word_count++;
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        go_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return '1;
            2: return '0;
            3: return $urandom_range(31);
            4: return -$urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_corners();
        send_word(rvalu_pkg::CMD_ADD, '1, 32'd1, 0, 5'd31);
        send_word(rvalu_pkg::CMD_SUB, 0, 32'd1, 0, 5'd0);
        send_word(rvalu_pkg::CMD_SLL, 32'h8000_0001, 32'hffff_ffff, 0, 5'd1);
        send_word(rvalu_pkg::CMD_SLT, 32'h8000_0000, 32'h7fff_ffff, 0, 5'd2);
        send_word(rvalu_pkg::CMD_SLTU, 32'h8000_0000, 32'h7fff_ffff, 0, 5'd3);
        send_word(rvalu_pkg::CMD_XOR, 32'haaaa_5555, '1, 0, 5'd4);
        send_word(rvalu_pkg::CMD_SRL, 32'h8000_0000, 32'd31, 0, 5'd5);
        send_word(rvalu_pkg::CMD_SRA, 32'h8000_0000, 32'd31, 0, 5'd6);
        send_word(rvalu_pkg::CMD_OR, 32'h0f0f_0f0f, 32'hf0f0_0000, 0, 5'd7);
        send_word(rvalu_pkg::CMD_AND, '1, 32'h1234_5678, 0, 5'd8);
        send_word(rvalu_pkg::CMD_MUL, '1, '1, 0, 5'd9);
        send_word(rvalu_pkg::CMD_MULH, 32'h8000_0000, 32'h8000_0000, 0, 5'd10);
        send_word(rvalu_pkg::CMD_MULHSU, '1, '1, 0, 5'd11);
        send_word(rvalu_pkg::CMD_MULHU, '1, '1, 0, 5'd12);
        send_word(rvalu_pkg::CMD_DIV, 32'h8000_0000, '1, 0, 5'd13);
        send_word(rvalu_pkg::CMD_DIV, 32'd7, 0, 0, 5'd14);
        send_word(rvalu_pkg::CMD_DIVU, 32'd7, 0, 0, 5'd15);
        send_word(rvalu_pkg::CMD_REM, 32'h8000_0000, '1, 0, 5'd16);
        send_word(rvalu_pkg::CMD_REM, 32'hffff_fff9, 0, 0, 5'd17);
        send_word(rvalu_pkg::CMD_REMU, 32'd9, 0, 0, 5'd18);
        send_word(rvalu_pkg::CMD_DIV, 32'hffff_fff9, 32'd2, 0, 5'd19);
        send_word(rvalu_pkg::CMD_LUI, 0, 32'hfffff000, 0, 5'd20);
        send_word(rvalu_pkg::CMD_AUIPC, 0, 32'hfffff000, 32'hffff_fffc, 5'd21);
        send_word(5'd20, '1, '1, '1, 5'd22);
        send_word(5'd31, '1, '1, '1, 5'd23);
        drain();
    endtask

    task automatic test_random_ops(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_word($urandom_range(99) < 90 ? 5'($urandom_range(19)) : 5'($urandom),
                      random_operand(), random_operand(), $urandom, 5'($urandom));
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        alu_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_res.value)
                begin
                    $error("result_value expected %h actual %h", exp_res.value,
                           m_axis_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[36:32] !== exp_res.dest)
                begin
                    $error("result_dest expected %0d actual %0d", exp_res.dest,
                           m_axis_tdata[36:32]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        timed_out = 1'b1;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed_corners();
        test_random_ops(250, 0, 0);
        test_random_ops(150, 75, 0);
        test_random_ops(150, 0, 75);
        test_random_ops(250, 12, 12);
        recv_stall_pct = 0;
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            $error("%0d results never arrived", pending_results.size());
        $display("covered all rv32im operations, unused codes and divide corners");
        $display("%0d words sent, %0d results checked", word_count, result_count);
        if (mismatch_count == 0 && pending_results.size() == 0 && !timed_out)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
